// ===== src/psvf_pkg.sv =====
// Shared types and constants of the parallel state-variable formant filter.
`default_nettype none

package psvf_pkg;

  // Sample and coefficient formats.
  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 18;
  localparam int MCOEF_W   = COEF_W + 1;
  localparam int COEF_FRAC = 17;
  localparam int IN_ALIGN  = 9;

  // Width of one operand slice fed to the shared multiplier per cycle.
  localparam int CHUNK_W = 24;

  // Configuration port.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 3 * COEF_W;

  // Command field widths, sized for at most four bands and four slices.
  localparam int BAND_SEL_W  = 2;
  localparam int CHUNK_SEL_W = 2;

  // Unity in unsigned Q1.17, held as a signed multiplier operand.
  localparam logic signed [MCOEF_W-1:0] UNITY_WEIGHT = 19'sd131072;

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_COEFS  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SECOND_COEFS = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_THIRD_COEFS  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BAND_GAINS   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_WET_MIX      = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_DRAIN,
    ST_OUT
  } state_t;

  // Coefficient-by-operand products, in the order the sequencer issues them.
  typedef enum logic [2:0] {
    OP_A1_S1,
    OP_A2_V3,
    OP_A2_S1,
    OP_A3_V3,
    OP_G_V1,
    OP_DRY_V0,
    OP_WET_W
  } op_t;

  // Command word from the controller to the datapath.
  typedef struct packed {
    logic                   start;
    logic                   load;
    logic                   issue;
    op_t                    op;
    logic [CHUNK_SEL_W-1:0] chunk;
    logic                   first;
    logic                   last;
    logic [BAND_SEL_W-1:0]  band;
    logic                   out_write;
  } cmd_t;

endpackage

`default_nettype wire

// ===== src/psvf_controller.sv =====
// Sequencer that steps each sample through the bands and the shared multiplier.
`default_nettype none

module psvf_controller #(
  parameter int NUM_BANDS   = 3,
  parameter int STATE_WIDTH = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output psvf_pkg::cmd_t  cmd
);
  import psvf_pkg::*;

  localparam int OPER_W     = STATE_WIDTH + 7;
  localparam int NUM_CHUNKS = (OPER_W + CHUNK_W - 1) / CHUNK_W;
  localparam logic [CHUNK_SEL_W-1:0] TOP_CHUNK = CHUNK_SEL_W'(NUM_CHUNKS - 1);
  localparam logic [BAND_SEL_W-1:0]  LAST_BAND = BAND_SEL_W'(NUM_BANDS - 1);

  state_t                 state, state_next;
  op_t                    op, op_next;
  logic [BAND_SEL_W-1:0]  band, band_next;
  logic [CHUNK_SEL_W-1:0] chunk, chunk_next;
  logic                   drain, drain_next;
  logic                   out_valid_next;

  // State and sequencing registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      op        <= OP_A1_S1;
      band      <= '0;
      chunk     <= '0;
      drain     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      op        <= op_next;
      band      <= band_next;
      chunk     <= chunk_next;
      drain     <= drain_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next    = state;
    op_next       = op;
    band_next     = band;
    chunk_next    = chunk;
    drain_next    = drain;
    in_stall      = 1'b1;
    cmd           = '0;
    cmd.op        = op;
    cmd.chunk     = chunk;
    cmd.band      = band;

    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.start  = 1'b1;
          band_next  = '0;
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        op_next    = OP_A1_S1;
        chunk_next = TOP_CHUNK;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        // One operand slice per cycle, most significant slice first.
        cmd.issue = 1'b1;
        cmd.first = (chunk == TOP_CHUNK);
        cmd.last  = (chunk == '0);
        if (chunk == '0) begin
          chunk_next = TOP_CHUNK;
          if (op == OP_G_V1 || op == OP_WET_W) begin
            drain_next = 1'b0;
            state_next = ST_DRAIN;
          end else begin
            case (op)
              OP_A1_S1:  op_next = OP_A2_V3;
              OP_A2_V3:  op_next = OP_A2_S1;
              OP_A2_S1:  op_next = OP_A3_V3;
              OP_A3_V3:  op_next = OP_G_V1;
              OP_DRY_V0: op_next = OP_WET_W;
              default:   op_next = op;
            endcase
          end
        end else begin
          chunk_next = chunk - 1'b1;
        end
      end
      ST_DRAIN: begin
        // The drain state waits while the last product reaches its accumulator.
        drain_next = 1'b1;
        if (drain) begin
          if (op == OP_WET_W) begin
            state_next = ST_OUT;
          end else if (band == LAST_BAND) begin
            op_next    = OP_DRY_V0;
            state_next = ST_MUL;
          end else begin
            band_next  = band + 1'b1;
            state_next = ST_LOAD;
          end
        end
      end
      ST_OUT: begin
        if (!out_valid || !out_stall) begin
          cmd.out_write = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    // The output register holds its request until the receiver takes it.
    out_valid_next = (out_valid && out_stall) || cmd.out_write;
  end

endmodule

`default_nettype wire

// ===== src/psvf_datapath.sv =====
// Coefficient registers, integrator states and the shared multiply-round datapath.
`default_nettype none

module psvf_datapath #(
  parameter int NUM_BANDS   = 3,
  parameter int STATE_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  psvf_pkg::cmd_t                        cmd,
  input  logic                                  cfg_write,
  input  logic [psvf_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [psvf_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic signed [psvf_pkg::SAMPLE_W-1:0]  sample_in,
  output logic signed [psvf_pkg::SAMPLE_W-1:0]  sample_out
);
  import psvf_pkg::*;

  // Widths of the signal chain, sized from the wider of the state and the aligned
  // input; the operand width covers twice the wet sum.
  localparam int V0_W       = SAMPLE_W + IN_ALIGN;
  localparam int SIG_W      = (STATE_WIDTH > V0_W) ? STATE_WIDTH : V0_W;
  localparam int OPER_W     = SIG_W + 7;
  localparam int NUM_CHUNKS = (OPER_W + CHUNK_W - 1) / CHUNK_W;
  localparam int PAD_W      = NUM_CHUNKS * CHUNK_W;
  localparam int PROD_W     = MCOEF_W + CHUNK_W + 1;
  localparam int ACC_W      = OPER_W + MCOEF_W;
  localparam int RND_W      = ACC_W - COEF_FRAC;
  localparam int V3_W       = SIG_W + 1;
  localparam int V_W        = SIG_W + 3;
  localparam int WET_W      = SIG_W + 6;
  localparam int UPD_W      = SIG_W + 4;
  localparam int BIDX_W     = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;

  localparam logic signed [ACC_W-1:0] PROD_HALF = ACC_W'(1) <<< (COEF_FRAC - 1);
  localparam logic signed [RND_W-1:0] OUT_HALF  = RND_W'(1) <<< (IN_ALIGN - 1);

  // Configuration.
  logic [COEF_W-1:0]         a1 [NUM_BANDS];
  logic [COEF_W-1:0]         a2 [NUM_BANDS];
  logic [COEF_W-1:0]         a3 [NUM_BANDS];
  logic [COEF_W-1:0]         gain [NUM_BANDS];
  logic [COEF_W-1:0]         wet_weight;
  logic signed [MCOEF_W-1:0] dry_weight;

  // Filter state and working values.
  logic signed [STATE_WIDTH-1:0] s1 [NUM_BANDS];
  logic signed [STATE_WIDTH-1:0] s2 [NUM_BANDS];
  logic signed [STATE_WIDTH-1:0] s1_next, s2_next;
  logic signed [V0_W-1:0]        v0;
  logic signed [V3_W-1:0]        v3;
  logic signed [V_W-1:0]         v1, v2;
  logic signed [WET_W-1:0]       wet;
  logic signed [RND_W-1:0]       y;
  logic signed [RND_W-1:0]       y_round;
  logic signed [SAMPLE_W-1:0]    out_next;
  logic [BIDX_W-1:0]             bidx;

  // Multiplier pipeline.
  logic signed [PAD_W-1:0]     oper;
  logic signed [MCOEF_W-1:0]   coef;
  logic signed [CHUNK_W:0]     chunk_s;
  logic signed [PROD_W-1:0]    prod;
  logic                        m_valid, m_first, m_last;
  op_t                         m_op;
  logic signed [ACC_W-1:0]     acc, acc_base, acc_sum;
  logic signed [RND_W-1:0]     rnd;
  logic                        a_valid;
  op_t                         a_op;
  logic signed [UPD_W-1:0]     upd1, upd2;

  assign bidx = cmd.band[BIDX_W-1:0];

  // Clamp an integrator update to the state width.
  function automatic logic signed [STATE_WIDTH-1:0] sat_state(
    input logic signed [UPD_W-1:0] x
  );
    logic signed [STATE_WIDTH-1:0] r;
    if (x[UPD_W-1:STATE_WIDTH-1] == '0 || x[UPD_W-1:STATE_WIDTH-1] == '1) begin
      r = x[STATE_WIDTH-1:0];
    end else begin
      r = {x[UPD_W-1], {(STATE_WIDTH-1){~x[UPD_W-1]}}};
    end
    return r;
  endfunction

  // Configuration register writes; the dry weight is derived when wet_mix lands.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < NUM_BANDS; b++) begin
        a1[b]   <= '0;
        a2[b]   <= '0;
        a3[b]   <= '0;
        gain[b] <= '0;
      end
      wet_weight <= '0;
      dry_weight <= UNITY_WEIGHT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FIRST_COEFS: begin
          for (int b = 0; b < NUM_BANDS; b++) a1[b] <= cfg_data[COEF_W*b +: COEF_W];
        end
        REG_SECOND_COEFS: begin
          for (int b = 0; b < NUM_BANDS; b++) a2[b] <= cfg_data[COEF_W*b +: COEF_W];
        end
        REG_THIRD_COEFS: begin
          for (int b = 0; b < NUM_BANDS; b++) a3[b] <= cfg_data[COEF_W*b +: COEF_W];
        end
        REG_BAND_GAINS: begin
          for (int b = 0; b < NUM_BANDS; b++) gain[b] <= cfg_data[COEF_W*b +: COEF_W];
        end
        REG_WET_MIX: begin
          wet_weight <= cfg_data[COEF_W-1:0];
          dry_weight <= UNITY_WEIGHT - signed'({1'b0, cfg_data[COEF_W-1:0]});
        end
        default: ;
      endcase
    end
  end

  // Operand and coefficient selection for the current product.
  always_comb begin
    case (cmd.op) inside
      OP_A1_S1, OP_A2_S1: oper = PAD_W'(s1[bidx]);
      OP_A2_V3, OP_A3_V3: oper = PAD_W'(v3);
      OP_G_V1:            oper = PAD_W'(v1);
      OP_DRY_V0:          oper = PAD_W'(v0);
      OP_WET_W:           oper = PAD_W'(wet) <<< 1;
      default:            oper = '0;
    endcase

    case (cmd.op) inside
      OP_A1_S1:           coef = signed'({1'b0, a1[bidx]});
      OP_A2_V3, OP_A2_S1: coef = signed'({1'b0, a2[bidx]});
      OP_A3_V3:           coef = signed'({1'b0, a3[bidx]});
      OP_G_V1:            coef = signed'({1'b0, gain[bidx]});
      OP_DRY_V0:          coef = dry_weight;
      OP_WET_W:           coef = signed'({1'b0, wet_weight});
      default:            coef = '0;
    endcase

    // The top slice carries the sign; lower slices are unsigned.
    chunk_s = '0;
    for (int j = 0; j < NUM_CHUNKS; j++) begin
      if (CHUNK_SEL_W'(j) == cmd.chunk) begin
        if (j == NUM_CHUNKS - 1) begin
          chunk_s = signed'({oper[PAD_W-1], oper[j*CHUNK_W +: CHUNK_W]});
        end else begin
          chunk_s = signed'({1'b0, oper[j*CHUNK_W +: CHUNK_W]});
        end
      end
    end
  end

  // Multiplier stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= cmd.issue;
    end
    prod    <= coef * chunk_s;
    m_first <= cmd.first;
    m_last  <= cmd.last;
    m_op    <= cmd.op;
  end

  // Slice accumulation; the rounding half is added with the lowest slice.
  always_comb begin
    acc_base = m_first ? '0 : (acc <<< CHUNK_W);
    acc_sum  = acc_base + ACC_W'(prod) + (m_last ? PROD_HALF : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= m_valid && m_last;
    end
    if (m_valid) begin
      acc <= acc_sum;
      if (m_last) begin
        rnd <= acc_sum[ACC_W-1:COEF_FRAC];
      end
    end
    a_op <= m_op;
  end

  // Integrator updates, applied with the band's gain product.
  always_comb begin
    upd1    = (UPD_W'(v1) <<< 1) - UPD_W'(s1[bidx]);
    upd2    = (UPD_W'(v2) <<< 1) - UPD_W'(s2[bidx]);
    s1_next = sat_state(upd1);
    s2_next = sat_state(upd2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < NUM_BANDS; b++) begin
        s1[b] <= '0;
        s2[b] <= '0;
      end
    end else if (a_valid && a_op == OP_G_V1) begin
      s1[bidx] <= s1_next;
      s2[bidx] <= s2_next;
    end
  end

  // Working registers: sample intake, band setup and product commits.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      v0  <= V0_W'(sample_in) <<< IN_ALIGN;
      wet <= '0;
      y   <= '0;
    end
    if (cmd.load) begin
      v3 <= V3_W'(v0) - V3_W'(s2[bidx]);
      v1 <= '0;
      v2 <= V_W'(s2[bidx]);
    end
    if (a_valid) begin
      case (a_op) inside
        OP_A1_S1, OP_A2_V3:  v1  <= v1 + V_W'(rnd);
        OP_A2_S1, OP_A3_V3:  v2  <= v2 + V_W'(rnd);
        OP_G_V1:             wet <= wet + WET_W'(rnd);
        OP_DRY_V0, OP_WET_W: y   <= y + rnd;
        default: ;
      endcase
    end
    if (cmd.out_write) begin
      sample_out <= out_next;
    end
  end

  // Output rounding to Q1.15 with saturation.
  always_comb begin
    y_round = (y + OUT_HALF) >>> IN_ALIGN;
    if (y_round[RND_W-1:SAMPLE_W-1] == '0 || y_round[RND_W-1:SAMPLE_W-1] == '1) begin
      out_next = y_round[SAMPLE_W-1:0];
    end else begin
      out_next = {y_round[RND_W-1], {(SAMPLE_W-1){~y_round[RND_W-1]}}};
    end
  end

endmodule

`default_nettype wire

// ===== src/parallel_svf_formant_filter_top.sv =====
// Top level of the parallel state-variable bandpass formant filter.
//
// Usage: one signed Q1.15 sample enters on the input channel (in_valid, in_stall)
// and one filtered, wet/dry mixed sample leaves on the output channel
// (out_valid, out_stall). A request is taken when valid is high and stall is low.
// Coefficients are written on the configuration channel (cfg_valid, cfg_ready,
// cfg_index, cfg_data) while no sample is in flight; cfg_ready is always high.
// Each product is formed on the single 19 x 25 multiplier, one slice per cycle, in
// N = ceil((STATE_WIDTH + 7) / 24) operand slices. A new sample is accepted the
// cycle after the result is registered, so no new sample is taken while one is
// still being processed.
// A finished result waits in the output register while the receiver stalls;
// the next sample is accepted and processed meanwhile, and its result is held
// back until the previous one is taken.
// Synchronous reset clears the integrators, the coefficients (wet mix to zero,
// so the output is dry), and all handshake state.
`default_nettype none

module parallel_svf_formant_filter_top #(
  parameter int NUM_BANDS   = 3,
  parameter int STATE_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [psvf_pkg::SAMPLE_W-1:0]  sample_in,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [psvf_pkg::SAMPLE_W-1:0]  sample_out,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [psvf_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [psvf_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import psvf_pkg::*;

  cmd_t cmd;
  logic cfg_write;

  // Register writes are always accepted.
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  psvf_controller #(
    .NUM_BANDS   (NUM_BANDS),
    .STATE_WIDTH (STATE_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  psvf_datapath #(
    .NUM_BANDS   (NUM_BANDS),
    .STATE_WIDTH (STATE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample_in  (sample_in),
    .sample_out (sample_out)
  );

endmodule

`default_nettype wire

// ===== src/psvf_checker.sv =====
// Port-level checks of the formant filter, bound to the top level.
`default_nettype none

module psvf_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_valid,
  input logic                                  in_stall,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic signed [psvf_pkg::SAMPLE_W-1:0]  sample_out
);

  // Leaving reset, the block is ready for a sample and holds no result.
  assert property (@(posedge clk) $past(rst) && !rst |-> !in_stall && !out_valid)
    else $error("block not idle after reset");

  // An accepted sample keeps the block busy on the following cycle.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second sample accepted while one is in flight");

  // A new result cannot appear right after a sample is accepted.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> !$rose(out_valid))
    else $error("result raised immediately after acceptance");

  // A fresh result is registered only when processing has finished.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_stall)
    else $error("result raised while a sample is still in flight");

  // A stalled result stays valid and unchanged.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(sample_out))
    else $error("stalled result dropped or changed");

endmodule

bind parallel_svf_formant_filter_top psvf_checker u_psvf_checker (.*);

`default_nettype wire
